### rtl/core/ptc_pkg.sv
`default_nettype none

package ptc_pkg;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } ptc_sample_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] pressure_value;
  } ptc_result_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int MODEL_W     = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_SENS_COEFF        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_COEFF      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REF_TEMPERATURE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TEMP_SENSITIVITY  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MODEL_SELECT      = 3'd6;

  localparam logic [MODEL_W-1:0] MODEL_1BAR  = 3'd0;
  localparam logic [MODEL_W-1:0] MODEL_2BAR  = 3'd1;
  localparam logic [MODEL_W-1:0] MODEL_5BAR  = 3'd2;
  localparam logic [MODEL_W-1:0] MODEL_14BAR = 3'd3;
  localparam logic [MODEL_W-1:0] MODEL_30BAR = 3'd4;

  // Temperatures in hundredths of a degree.
  localparam int TEMP_REF   = 2000;
  localparam int TEMP_FROST = -1500;
  localparam int TEMP_HOT   = 4500;

  localparam int WIDE_W = 44;
  typedef logic signed [WIDE_W-1:0] wide_t;

endpackage

`default_nettype wire

### rtl/core/pressure_temperature_compensation_top.sv
// Pressure and temperature compensation for a family of 24-bit pressure sensors.
// Calibration words and the model select are written through the cfg_write,
// cfg_index and cfg_data port, one register per cycle. The user must write them
// only while no request is in flight; the block does not enforce this. Each
// request on the sample channel carries one raw pressure and one raw temperature
// conversion; it yields exactly one result with the temperature in hundredths of
// a degree and the compensated pressure. The datapath is a nine-stage pipeline,
// and one request is taken every cycle while sample_stall is low. The longest
// stages are one multiplier deep: the 25 by 25 bit square of dT beside the
// calibration products, the squares of the first-order temperature terms, and the
// two partial products of pressure times SENS.
// Reset clears all calibration registers and empties the pipeline; the outputs
// show no valid result in the cycle after reset.
// When the receiver raises result_stall, the result holds still and the
// pipeline keeps filling its empty stages; sample_stall rises only once every
// stage holds a request.
`default_nettype none

module pressure_temperature_compensation_top
  import ptc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire ptc_sample_t            sample,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output ptc_result_t                 result
);

  localparam int STAGES = 9;

  logic [15:0]        sens_coeff;
  logic [15:0]        offset_coeff;
  logic [15:0]        sens_temp_coeff;
  logic [15:0]        offset_temp_coeff;
  logic [15:0]        ref_temperature;
  logic [15:0]        temp_sensitivity;
  logic [MODEL_W-1:0] model_select;

  logic [STAGES:1] v;
  logic [STAGES:1] en;

  logic [23:0]        d1_s1;
  logic signed [24:0] dt_s1;

  logic [23:0]        d1_s2;
  logic signed [41:0] p_temp_s2;
  logic signed [41:0] p_off_s2;
  logic signed [41:0] p_sens_s2;
  logic [47:0]        dt2_s2;
  logic signed [49:0] dt_sq;

  logic [23:0]        d1_s3;
  logic signed [19:0] temp1_s3;
  logic signed [18:0] s_s3;
  logic signed [19:0] tp_s3;
  logic signed [19:0] tq_s3;
  logic               cold_s3;
  logic               frost_s3;
  logic               hot_s3;
  wide_t              off_s3;
  wide_t              sens_s3;
  logic [18:0]        t2_s3;
  logic signed [18:0] s_next;
  logic signed [19:0] tp_next;
  logic signed [19:0] tq_next;
  wide_t              off_next;
  wide_t              sens_next;
  logic [18:0]        t2_next;
  logic [50:0]        dt2x3;
  logic [50:0]        dt2x7;

  logic [23:0]        d1_s4;
  logic signed [20:0] temp_s4;
  logic [37:0]        lo_s4;
  logic [37:0]        mi_s4;
  logic [37:0]        hq_s4;
  logic               cold_s4;
  logic               frost_s4;
  logic               hot_s4;
  wide_t              off_s4;
  wide_t              sens_s4;
  logic signed [37:0] sq_lo;
  logic signed [39:0] sq_mi;
  logic signed [39:0] sq_hq;

  logic [23:0]        d1_s5;
  logic signed [20:0] temp_s5;
  wide_t              off_s5;
  wide_t              sens_s5;
  logic [WIDE_W-1:0]  off2_s5;
  wide_t              sens2_s5;
  logic [WIDE_W-1:0]  off2_next;
  wide_t              sens2_next;
  logic [WIDE_W-1:0]  l_w;
  logic [WIDE_W-1:0]  m_w;
  logic [WIDE_W-1:0]  h_w;
  logic [WIDE_W-1:0]  l3;
  logic [WIDE_W-1:0]  l5;
  logic [WIDE_W-1:0]  l7;
  logic [WIDE_W-1:0]  l61;
  logic [WIDE_W-1:0]  m3;
  logic [WIDE_W-1:0]  m7;
  logic [WIDE_W-1:0]  m12;
  logic [WIDE_W-1:0]  m20;

  logic [23:0]        d1_s6;
  logic signed [20:0] temp_s6;
  wide_t              off_s6;
  wide_t              sens_s6;

  logic signed [20:0] temp_s7;
  wide_t              off_s7;
  logic [45:0]        pp_lo_s7;
  logic signed [46:0] pp_hi_s7;

  logic signed [20:0] temp_s8;
  wide_t              off_s8;
  logic signed [68:0] prod_s8;

  logic signed [48:0] q_next;
  logic signed [31:0] p_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff        <= '0;
      offset_coeff      <= '0;
      sens_temp_coeff   <= '0;
      offset_temp_coeff <= '0;
      ref_temperature   <= '0;
      temp_sensitivity  <= '0;
      model_select      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SENS_COEFF:        sens_coeff        <= cfg_data;
        REG_OFFSET_COEFF:      offset_coeff      <= cfg_data;
        REG_SENS_TEMP_COEFF:   sens_temp_coeff   <= cfg_data;
        REG_OFFSET_TEMP_COEFF: offset_temp_coeff <= cfg_data;
        REG_REF_TEMPERATURE:   ref_temperature   <= cfg_data;
        REG_TEMP_SENSITIVITY:  temp_sensitivity  <= cfg_data;
        REG_MODEL_SELECT:      model_select      <= cfg_data[MODEL_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage takes new contents when it is empty or its successor moves on.
  always_comb begin
    en[STAGES] = !v[STAGES] || !result_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= sample_valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign sample_stall = !en[1];
  assign result_valid = v[STAGES];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_s1 <= sample.raw_pressure;
      dt_s1 <= $signed({1'b0, sample.raw_temperature})
             - $signed({1'b0, ref_temperature, 8'b0});
    end
  end

  assign dt_sq = dt_s1 * dt_s1;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_s2     <= d1_s1;
      p_temp_s2 <= dt_s1 * $signed({1'b0, temp_sensitivity});
      p_off_s2  <= dt_s1 * $signed({1'b0, offset_temp_coeff});
      p_sens_s2 <= dt_s1 * $signed({1'b0, sens_temp_coeff});
      dt2_s2    <= dt_sq[47:0];
    end
  end

  always_comb begin
    s_next  = 19'(p_temp_s2 >>> 23);
    tp_next = 20'(s_next) + 20'(TEMP_REF - TEMP_FROST);
    tq_next = 20'(s_next) - 20'(TEMP_HOT - TEMP_REF);
    dt2x3   = 51'(dt2_s2) + 51'({dt2_s2, 1'b0});
    dt2x7   = 51'({dt2_s2, 3'b0}) - 51'(dt2_s2);
    case (model_select)
      MODEL_1BAR, MODEL_14BAR, MODEL_30BAR: begin
        off_next  = (wide_t'(offset_coeff) <<< 16) + wide_t'(p_off_s2 >>> 7);
        sens_next = (wide_t'(sens_coeff) <<< 15) + wide_t'(p_sens_s2 >>> 8);
      end
      MODEL_2BAR: begin
        off_next  = (wide_t'(offset_coeff) <<< 17) + wide_t'(p_off_s2 >>> 6);
        sens_next = (wide_t'(sens_coeff) <<< 16) + wide_t'(p_sens_s2 >>> 7);
      end
      MODEL_5BAR: begin
        off_next  = (wide_t'(offset_coeff) <<< 18) + wide_t'(p_off_s2 >>> 5);
        sens_next = (wide_t'(sens_coeff) <<< 17) + wide_t'(p_sens_s2 >>> 7);
      end
      default: begin
        off_next  = '0;
        sens_next = '0;
      end
    endcase
    case (model_select)
      MODEL_1BAR, MODEL_2BAR: t2_next = s_next[18] ? 19'(dt2x3 >> 31) : '0;
      MODEL_5BAR:             t2_next = s_next[18] ? 19'(dt2x3 >> 33) : '0;
      MODEL_14BAR, MODEL_30BAR: begin
        t2_next = s_next[18] ? 19'(dt2x3 >> 33) : 19'(dt2x7 >> 37);
      end
      default: t2_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d1_s3    <= d1_s2;
      s_s3     <= s_next;
      temp1_s3 <= 20'(s_next) + 20'(TEMP_REF);
      tp_s3    <= tp_next;
      tq_s3    <= tq_next;
      cold_s3  <= s_next[18];
      frost_s3 <= tp_next[19];
      hot_s3   <= !tq_next[19];
      off_s3   <= off_next;
      sens_s3  <= sens_next;
      t2_s3    <= t2_next;
    end
  end

  assign sq_lo = s_s3 * s_s3;
  assign sq_mi = tp_s3 * tp_s3;
  assign sq_hq = tq_s3 * tq_s3;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      d1_s4    <= d1_s3;
      temp_s4  <= 21'(temp1_s3) - 21'({1'b0, t2_s3});
      lo_s4    <= sq_lo[37:0];
      mi_s4    <= sq_mi[37:0];
      hq_s4    <= sq_hq[37:0];
      cold_s4  <= cold_s3;
      frost_s4 <= frost_s3;
      hot_s4   <= hot_s3;
      off_s4   <= off_s3;
      sens_s4  <= sens_s3;
    end
  end

  always_comb begin
    l_w = WIDE_W'(lo_s4);
    m_w = WIDE_W'(mi_s4);
    h_w = WIDE_W'(hq_s4);
    l3  = (l_w << 1) + l_w;
    l5  = (l_w << 2) + l_w;
    l7  = (l_w << 3) - l_w;
    l61 = (l_w << 6) - (l_w << 1) - l_w;
    m3  = (m_w << 1) + m_w;
    m7  = (m_w << 3) - m_w;
    m12 = (m_w << 3) + (m_w << 2);
    m20 = (m_w << 4) + (m_w << 2);
    off2_next  = '0;
    sens2_next = '0;
    case (model_select)
      MODEL_1BAR: begin
        if (cold_s4) begin
          off2_next  = l3;
          sens2_next = wide_t'((l7 >> 3) + (frost_s4 ? (m_w << 1) : '0));
        end else if (hot_s4) begin
          sens2_next = -wide_t'(h_w >> 3);
        end
      end
      MODEL_2BAR: begin
        if (cold_s4) begin
          off2_next  = (l61 >> 4) + (frost_s4 ? m20 : '0);
          sens2_next = wide_t'((l_w << 1) + (frost_s4 ? m12 : '0));
        end
      end
      MODEL_5BAR: begin
        if (cold_s4) begin
          off2_next  = l3 >> 3;
          sens2_next = wide_t'((l7 >> 3) + (frost_s4 ? m3 : '0));
        end
      end
      MODEL_14BAR, MODEL_30BAR: begin
        if (cold_s4) begin
          off2_next  = (l3 >> 1) + (frost_s4 ? m7 : '0);
          sens2_next = wide_t'((l5 >> 3) + (frost_s4 ? (m_w << 2) : '0));
        end else begin
          off2_next = l_w >> 4;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      d1_s5    <= d1_s4;
      temp_s5  <= temp_s4;
      off_s5   <= off_s4;
      sens_s5  <= sens_s4;
      off2_s5  <= off2_next;
      sens2_s5 <= sens2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      d1_s6   <= d1_s5;
      temp_s6 <= temp_s5;
      off_s6  <= off_s5 - wide_t'(off2_s5);
      sens_s6 <= sens_s5 - sens2_s5;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      temp_s7  <= temp_s6;
      off_s7   <= off_s6;
      pp_lo_s7 <= d1_s6 * sens_s6[21:0];
      pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens_s6[WIDE_W-1:22]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      temp_s8 <= temp_s7;
      off_s8  <= off_s7;
      prod_s8 <= (69'(pp_hi_s7) <<< 22) + 69'(pp_lo_s7);
    end
  end

  always_comb begin
    q_next = 49'(prod_s8 >>> 21) - 49'(off_s8);
    case (model_select)
      MODEL_1BAR, MODEL_2BAR, MODEL_5BAR, MODEL_14BAR: p_next = 32'(q_next >>> 15);
      MODEL_30BAR: p_next = 32'(q_next >>> 13);
      default:     p_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      result.temperature_centi <= 32'(temp_s8);
      result.pressure_value    <= p_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ptc_checker.sv
`default_nettype none

module ptc_checker
  import ptc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        sample_stall,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire ptc_result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or vanished");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && result_stall)
    else $error("request refused while the pipeline can move");

  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.temperature_centi[31:20] == 12'h000) ||
                     (result.temperature_centi[31:20] == 12'hfff))
    else $error("temperature outside the reachable range");

endmodule

bind pressure_temperature_compensation_top ptc_checker u_ptc_checker (.*);

`default_nettype wire
